/* rtl/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// bb3_pkg
// Types, register codes and divisor table shared by the 3x3 box blur.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

  localparam int ROW_W      = 13;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int RECIP_SHIFT  = 18;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef logic [23:0] px_t;

  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } mask_t;

  typedef struct packed {
    px_t   top;
    px_t   mid;
    px_t   pix;
    logic  due;
    mask_t mask;
    logic  eor;
    logic  eof;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eor;
    logic       eof;
  } result_t;

  // 2^18 / count rounded up; exact for every rounded sum the blur can form
  function automatic logic [RECIP_SHIFT:0] recip(input logic [3:0] count);
    logic [RECIP_SHIFT:0] m;
    case (count)
      4'd2:    m = 19'd131072;
      4'd3:    m = 19'd87382;
      4'd4:    m = 19'd65536;
      4'd6:    m = 19'd43691;
      4'd9:    m = 19'd29128;
      default: m = 19'd262144;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/bb3_fifo.sv */
// ----------------------------------------------------------------------------
// bb3_fifo
// Small register queue with fill level, show-ahead read.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [W-1:0]               data_i,
  input  wire logic                       pop_i,
  output logic      [W-1:0]               data_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic          do_pop;

  assign empty_o = (lvl_q == '0);
  assign level_o = lvl_q;
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    lvl_d = lvl_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      lvl_d = lvl_q + 1'b1;
    end else if (!push_i && do_pop) begin
      lvl_d = lvl_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/bb3_front.sv */
// ----------------------------------------------------------------------------
// bb3_front
// Accepts pixels, tracks frame position, reads and writes the line buffers
// and tags each beat with its output position and edge masks.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int QDEPTH    = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  output logic                                   full_o,
  input  wire logic [7:0]                        in_red_i,
  input  wire logic [7:0]                        in_green_i,
  input  wire logic [7:0]                        in_blue_i,
  input  wire logic                              flush_i,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [$clog2(QDEPTH+1)-1:0]       q_level_i,
  output logic                                   q_push_o,
  output bb3_pkg::item_t                         q_item_o
);

  import bb3_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int XW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
  localparam int LW = $clog2(QDEPTH+1);

  logic [FW_W-1:0]  frame_width_q;
  logic [FH_W-1:0]  frame_height_q;
  logic [CW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  logic [XW-1:0]    weff, col_nx, ocol_nx;
  logic [FH_W-1:0]  heff;
  logic [ROW_W:0]   orow_nx;
  logic             acc, due, last_col, last_row, cfg_we, cfg_hit;
  px_t              pix;

  px_t              mem0 [MAX_WIDTH];
  px_t              mem1 [MAX_WIDTH];
  px_t              rd0_q, rd1_q, pix_q;
  logic             bank_q, f1_valid_q, due_q, eor_q, eof_q;
  mask_t            mask_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && (cfg_index_i == REG_FRAME_WIDTH ||
                                  cfg_index_i == REG_FRAME_HEIGHT);

  assign full_o = ({1'b0, q_level_i} + {{LW{1'b0}}, f1_valid_q}) >= (LW+1)'(QDEPTH);
  assign acc    = push_i && !full_o;
  assign pix    = flush_i ? '0 : {in_blue_i, in_green_i, in_red_i};

  always_comb begin
    if (frame_width_q == '0) begin
      weff = XW'(1);
    end else if (XW'(frame_width_q) > XW'(MAX_WIDTH)) begin
      weff = XW'(MAX_WIDTH);
    end else begin
      weff = XW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      heff = FH_W'(1);
    end else if (frame_height_q > FH_W'(HEIGHT_LIMIT)) begin
      heff = FH_W'(HEIGHT_LIMIT);
    end else begin
      heff = frame_height_q;
    end
    col_nx   = XW'(in_col_q) + XW'(1);
    ocol_nx  = XW'(out_col_q) + XW'(1);
    orow_nx  = {1'b0, out_row_q} + (ROW_W+1)'(1);
    last_col = ocol_nx >= weff;
    last_row = orow_nx >= (ROW_W+1)'(heff);
    due      = (in_row_q >= ROW_W'(2) || (in_row_q == ROW_W'(1) && in_col_q != '0)) &&
               (out_row_q < ROW_W'(heff));
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (col_nx >= weff) begin
      in_col_d = '0;
      in_row_d = in_row_q + 1'b1;
    end else begin
      in_col_d = col_nx[CW-1:0];
    end
    if (due) begin
      if (last_col && last_row) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (last_col) begin
        out_col_d = '0;
        out_row_d = out_row_q + 1'b1;
      end else begin
        out_col_d = ocol_nx[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      in_col_q       <= '0;
      in_row_q       <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      f1_valid_q     <= 1'b0;
    end else begin
      f1_valid_q <= acc;
      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
          default: ;
        endcase
      end
      if (cfg_hit) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (acc) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
    end
  end

  // line buffers: read-before-write at the current column
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd0_q <= mem0[in_col_q];
      rd1_q <= mem1[in_col_q];
      if (!in_row_q[0]) begin
        mem0[in_col_q] <= pix;
      end else begin
        mem1[in_col_q] <= pix;
      end
      bank_q      <= in_row_q[0];
      pix_q       <= pix;
      due_q       <= due;
      mask_q.top  <= (out_row_q != '0);
      mask_q.bot  <= !last_row;
      mask_q.left <= (out_col_q != '0);
      mask_q.right <= !last_col;
      eor_q       <= last_col;
      eof_q       <= last_col && last_row;
    end
  end

  assign q_push_o      = f1_valid_q;
  assign q_item_o.top  = bank_q ? rd1_q : rd0_q;
  assign q_item_o.mid  = bank_q ? rd0_q : rd1_q;
  assign q_item_o.pix  = pix_q;
  assign q_item_o.due  = due_q;
  assign q_item_o.mask = mask_q;
  assign q_item_o.eor  = eor_q;
  assign q_item_o.eof  = eof_q;

endmodule

`default_nettype wire

/* rtl/bb3_back.sv */
// ----------------------------------------------------------------------------
// bb3_back
// Window shift, masked neighborhood sums and constant-divisor averaging
// into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_back #(
  parameter int ODEPTH = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire bb3_pkg::item_t q_item_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  wire logic           pop_i,
  output logic [7:0]          out_red_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_blue_o,
  output logic                end_of_row_o,
  output logic                end_of_frame_o
);

  import bb3_pkg::*;

  localparam int LW = $clog2(ODEPTH+1);

  px_t              win1_q [3];
  px_t              win2_q [3];
  px_t              l_q [3];
  px_t              c_q [3];
  px_t              r_q [3];
  mask_t            m_q;
  logic             b1_v_q, b1_eor_q, b1_eof_q;
  logic             b2_v_q, b2_eor_q, b2_eof_q;
  logic [11:0]      n_q [3];
  logic [3:0]       cnt_q;
  logic [11:0]      n_d [3];
  logic [3:0]       cnt_d;
  logic [1:0]       nrow, ncol;
  logic [LW-1:0]    olevel;
  logic [LW+1:0]    used;
  logic [30:0]      prod [3];
  logic [RECIP_SHIFT:0] m;
  result_t          res_in, res_out;

  assign used    = (LW+2)'(olevel) + (LW+2)'(b1_v_q) + (LW+2)'(b2_v_q);
  assign q_pop_o = !q_empty_i && (used < (LW+2)'(ODEPTH));

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      win1_q[0] <= win2_q[0];
      win1_q[1] <= win2_q[1];
      win1_q[2] <= win2_q[2];
      win2_q[0] <= q_item_i.top;
      win2_q[1] <= q_item_i.mid;
      win2_q[2] <= q_item_i.pix;
      l_q       <= win1_q;
      c_q       <= win2_q;
      r_q[0]    <= q_item_i.top;
      r_q[1]    <= q_item_i.mid;
      r_q[2]    <= q_item_i.pix;
      m_q       <= q_item_i.mask;
      b1_eor_q  <= q_item_i.eor;
      b1_eof_q  <= q_item_i.eof;
    end
    n_q      <= n_d;
    cnt_q    <= cnt_d;
    b2_eor_q <= b1_eor_q;
    b2_eof_q <= b1_eof_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      b2_v_q <= 1'b0;
    end else begin
      b1_v_q <= q_pop_o && q_item_i.due;
      b2_v_q <= b1_v_q;
    end
  end

  always_comb begin
    nrow  = 2'd1 + 2'(m_q.top) + 2'(m_q.bot);
    ncol  = 2'd1 + 2'(m_q.left) + 2'(m_q.right);
    cnt_d = 4'(nrow) * 4'(ncol);
    for (int k = 0; k < 3; k++) begin
      n_d[k] = 12'(cnt_d >> 1);
      for (int ry = 0; ry < 3; ry++) begin
        if ((ry == 0 && m_q.top) || ry == 1 || (ry == 2 && m_q.bot)) begin
          n_d[k] = n_d[k] + 12'(c_q[ry][8*k +: 8]);
          if (m_q.left) n_d[k] = n_d[k] + 12'(l_q[ry][8*k +: 8]);
          if (m_q.right) n_d[k] = n_d[k] + 12'(r_q[ry][8*k +: 8]);
        end
      end
    end
  end

  always_comb begin
    m = recip(cnt_q);
    for (int k = 0; k < 3; k++) begin
      prod[k] = 31'(n_q[k]) * 31'(m);
    end
    res_in.red   = prod[0][RECIP_SHIFT +: 8];
    res_in.green = prod[1][RECIP_SHIFT +: 8];
    res_in.blue  = prod[2][RECIP_SHIFT +: 8];
    res_in.eor   = b2_eor_q;
    res_in.eof   = b2_eof_q;
  end

  bb3_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (ODEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b2_v_q),
    .data_i  (res_in),
    .pop_i   (pop_i),
    .data_o  (res_out),
    .empty_o (empty_o),
    .level_o (olevel)
  );

  assign out_red_o      = res_out.red;
  assign out_green_o    = res_out.green;
  assign out_blue_o     = res_out.blue;
  assign end_of_row_o   = res_out.eor;
  assign end_of_frame_o = res_out.eof;

endmodule

`default_nettype wire

/* rtl/box_blur_3x3_rgb.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 RGB box blur, averaged over in-frame neighbors only.
// ----------------------------------------------------------------------------
// channel   direction  handshake             beat
// pixel     in         push_i / full_o       in_red/green/blue, flush
// result    out        pop_i / empty_o       out_red/green/blue, end_of_row/frame
// config    in         cfg_valid/cfg_ready   cfg_index_i, cfg_data_i
//
// One pixel per clock while full_o is low; a result shows on the ports once the beat
// that completes it has passed the line buffer read, classify queue, window, sum and
// reciprocal multiply into the result queue.
// Line buffers are one-read one-write RAMs; no clearing pass after reset.
// A stalled result side backs up through the result and classify queues to full_o.
// Reset is asynchronous, active low; width and height writes restart the frame position.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic [7:0]                     in_red_i,
  input  wire logic [7:0]                     in_green_i,
  input  wire logic [7:0]                     in_blue_i,
  input  wire logic                           flush_i,
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output logic [7:0]                          out_red_o,
  output logic [7:0]                          out_green_o,
  output logic [7:0]                          out_blue_o,
  output logic                                end_of_row_o,
  output logic                                end_of_frame_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import bb3_pkg::*;

  localparam int QDEPTH = 4;

  logic                        q_push, q_pop, q_empty;
  item_t                       q_in, q_out;
  logic [$clog2(QDEPTH+1)-1:0] q_level;

  bb3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .QDEPTH    (QDEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .flush_i     (flush_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_level_i   (q_level),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  bb3_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (QDEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .level_o (q_level)
  );

  bb3_back #(
    .ODEPTH (4)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_item_i       (q_out),
    .q_pop_o        (q_pop),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule

`default_nettype wire

/* rtl/bb3_checker.sv */
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks for the box blur, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       full_o,
  input wire logic       empty_o,
  input wire logic       pop_i,
  input wire logic [7:0] out_red_o,
  input wire logic [7:0] out_green_o,
  input wire logic [7:0] out_blue_o,
  input wire logic       end_of_row_o,
  input wire logic       end_of_frame_o
);

  a_eof_is_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && end_of_frame_o |-> end_of_row_o)
    else $error("end of frame without end of row");

  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty_o && !full_o)
    else $error("queues not idle out of reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o)
    else $error("result beat dropped");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> $stable(out_red_o) && $stable(out_green_o) &&
      $stable(out_blue_o) && $stable(end_of_row_o) && $stable(end_of_frame_o))
    else $error("stalled result changed");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .full_o         (full_o),
  .empty_o        (empty_o),
  .pop_i          (pop_i),
  .out_red_o      (out_red_o),
  .out_green_o    (out_green_o),
  .out_blue_o     (out_blue_o),
  .end_of_row_o   (end_of_row_o),
  .end_of_frame_o (end_of_frame_o)
);

`default_nettype wire

/* tb/box_blur_3x3_rgb_test.sv */
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_test
// Self-checking bench for the streaming 3x3 RGB box blur. Frames of random
// pixels at many sizes, register extremes included, are pushed through the
// block. A behavioral predictor computes each blurred beat when its pixel is
// accepted, and the monitor compares every popped beat against the oldest
// prediction. Both sides idle at random; the result side also holds off for
// a long stretch so the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_blur_3x3_rgb_test;
  import bb3_pkg::*;

  localparam int MAXW = 1024;

  typedef enum {BEAT_PIXEL, BEAT_CFG, BEAT_SYNC} beat_kind_e;

  typedef struct {
    beat_kind_e  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        flush;
    cfg_reg_e    idx;
    logic [12:0] data;
  } beat_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eor;
    logic       eof;
  } blur_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push_i = 1'b0;
  logic [7:0]  in_red_i = '0;
  logic [7:0]  in_green_i = '0;
  logic [7:0]  in_blue_i = '0;
  logic        flush_i = 1'b0;
  logic        pop_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic        full_o, empty_o, cfg_ready_o, end_of_row_o, end_of_frame_o;
  logic [7:0]  out_red_o, out_green_o, out_blue_o;

  box_blur_3x3_rgb u_dut (
    .clk_i, .rst_ni, .push_i, .full_o, .in_red_i, .in_green_i, .in_blue_i,
    .flush_i, .empty_o, .pop_i, .out_red_o, .out_green_o, .out_blue_o,
    .end_of_row_o, .end_of_frame_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  beat_t pending_beats[$];
  blur_t blurred_q[$];
  int    errors = 0;
  bit    tail_phase = 1'b0;
  int    results_seen = 0;

  // predictor state
  logic [10:0] fw;
  logic [12:0] fh;
  px_t         lines [2*MAXW];
  px_t         win [9];
  int          in_col, in_row, out_col, out_row;

  function automatic int eff_w(int v);
    if (v == 0) return 1;
    if (v > MAXW) return MAXW;
    return v;
  endfunction

  function automatic int eff_h(int v);
    if (v == 0) return 1;
    if (v > HEIGHT_LIMIT) return HEIGHT_LIMIT;
    return v;
  endfunction

  task automatic blur_reset();
    fw = FRAME_WIDTH_RST;
    fh = FRAME_HEIGHT_RST;
    foreach (lines[i]) lines[i] = '0;
    foreach (win[i]) win[i] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  task automatic blur_config(cfg_reg_e idx, logic [12:0] data);
    if (idx == REG_FRAME_WIDTH) fw = data[10:0];
    else fh = data;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endtask

  function automatic blur_t window_mean(int cc, int w, int h);
    int sr, sg, sb, cnt, col;
    px_t p;
    blur_t res;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int ry = 0; ry < 3; ry++) begin
      if (ry == 0 && out_row == 0) continue;
      if (ry == 2 && out_row + 1 >= h) continue;
      for (int dx = 0; dx < 3; dx++) begin
        if (dx == 0 && out_col == 0) continue;
        if (dx == 2 && out_col + 1 >= w) continue;
        col = cc + dx - 1;
        if (col > 2) continue;
        p = win[ry*3 + col];
        sr += p[7:0]; sg += p[15:8]; sb += p[23:16];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    res.red   = 8'((sr + cnt/2) / cnt);
    res.green = 8'((sg + cnt/2) / cnt);
    res.blue  = 8'((sb + cnt/2) / cnt);
    res.eor = 1'b0; res.eof = 1'b0;
    return res;
  endfunction

  task automatic blur_pixel(beat_t bt);
    int w, h, r, c, bank;
    bit due, last;
    px_t pix, top, mid;
    blur_t res;
    w = eff_w(fw);
    h = eff_h(fh);
    pix = bt.flush ? '0 : {bt.blue, bt.green, bt.red};
    r = in_row;
    c = (in_col >= w) ? w - 1 : in_col;
    due = (r >= 2 || (r == 1 && c >= 1)) && out_row < h;
    last = (out_col + 1 >= w);
    if (due && last) res = window_mean(2, w, h);
    bank = r & 1;
    top = lines[bank*MAXW + c];
    mid = lines[(bank^1)*MAXW + c];
    lines[bank*MAXW + c] = pix;
    win[0] = win[1]; win[1] = win[2]; win[2] = top;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = pix;
    if (due && !last) res = window_mean(1, w, h);
    if (c + 1 >= w) begin
      in_col = 0; in_row = r + 1;
    end else begin
      in_col = c + 1;
    end
    if (due) begin
      res.eor = last;
      res.eof = last && (out_row + 1 >= h);
      blurred_q.push_back(res);
      if (res.eof) begin
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else if (res.eor) begin
        out_col = 0; out_row++;
      end else begin
        out_col++;
      end
    end
  endtask

  // driver
  beat_t cur;
  int    gap = 0;
  int    quiet = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_push, nxt_cfg;
    beat_t hd;
    if (!rst_ni) begin
      blur_reset();
      push_i <= 1'b0;
      cfg_valid_i <= 1'b0;
      gap = 0;
      quiet = 0;
    end else begin
      nxt_push = push_i;
      nxt_cfg = cfg_valid_i;
      if (push_i && !full_o) begin
        blur_pixel(cur);
        nxt_push = 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        blur_config(cur.idx, cur.data);
        nxt_cfg = 1'b0;
      end
      if (blurred_q.size() == 0 && !nxt_push && !nxt_cfg) quiet++;
      else quiet = 0;
      if (!nxt_push && !nxt_cfg) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_beats.size() > 0) begin
          hd = pending_beats[0];
          if (hd.kind == BEAT_PIXEL) begin
            void'(pending_beats.pop_front());
            cur = hd;
            nxt_push = 1'b1;
            in_red_i <= hd.red;
            in_green_i <= hd.green;
            in_blue_i <= hd.blue;
            flush_i <= hd.flush;
            if (!tail_phase && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 6);
          end else if (quiet >= 12) begin
            void'(pending_beats.pop_front());
            if (hd.kind == BEAT_CFG) begin
              cur = hd;
              nxt_cfg = 1'b1;
              cfg_index_i <= hd.idx;
              cfg_data_i <= hd.data;
            end
          end
        end
      end
      if (pending_beats.size() < 300) tail_phase = 1'b1;
      push_i <= nxt_push;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // monitor
  int hold = 0;

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blur_t e;
    logic nxt_pop;
    if (!rst_ni) begin
      pop_i <= 1'b0;
      hold = 0;
    end else begin
      if (pop_i && !empty_o) begin
        results_seen++;
        if (blurred_q.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          e = blurred_q.pop_front();
          check_field("out_red", e.red, out_red_o);
          check_field("out_green", e.green, out_green_o);
          check_field("out_blue", e.blue, out_blue_o);
          check_field("end_of_row", e.eor, end_of_row_o);
          check_field("end_of_frame", e.eof, end_of_frame_o);
        end
        if (results_seen == 100) hold = 400;
      end
      nxt_pop = 1'b1;
      if (hold > 0) begin
        hold--;
        nxt_pop = 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 6);
        nxt_pop = 1'b0;
      end
      pop_i <= nxt_pop;
    end
  end

  // stimulus
  int gen_w = 640, gen_h = 480;

  task automatic add_cfg(cfg_reg_e idx, int data);
    beat_t b;
    b.kind = BEAT_CFG; b.idx = idx; b.data = 13'(data);
    b.red = '0; b.green = '0; b.blue = '0; b.flush = 1'b0;
    pending_beats.push_back(b);
    if (idx == REG_FRAME_WIDTH) gen_w = eff_w(data & 'h7ff);
    else gen_h = eff_h(data & 'h1fff);
  endtask

  task automatic add_sync();
    beat_t b;
    b.kind = BEAT_SYNC; b.idx = REG_FRAME_WIDTH; b.data = '0;
    b.red = '0; b.green = '0; b.blue = '0; b.flush = 1'b0;
    pending_beats.push_back(b);
  endtask

  task automatic add_pixel(int r, int g, int b_v, bit fl);
    beat_t b;
    b.kind = BEAT_PIXEL; b.idx = REG_FRAME_WIDTH; b.data = '0;
    b.red = 8'(r); b.green = 8'(g); b.blue = 8'(b_v); b.flush = fl;
    pending_beats.push_back(b);
  endtask

  // frame of random pixels; cut > 0 stops after at most that many pixels
  task automatic add_frame(int noise, int cut);
    int n;
    n = gen_w * gen_h;
    if (cut > 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++)
      add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                noise > 0 && $urandom_range(0, noise) == 0);
    if (cut > 0) return;
    for (int i = 0; i <= gen_w; i++)
      add_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                !(noise > 0 && $urandom_range(0, 3) == 0));
  endtask

  initial begin
    int count;
    int ws, hs;
    // directed: 3x3 with extreme pixels, inside flush, pixel in drain
    add_cfg(REG_FRAME_WIDTH, 3);
    add_cfg(REG_FRAME_HEIGHT, 3);
    add_pixel(255, 255, 255, 0); add_pixel(0, 0, 0, 0); add_pixel(255, 0, 255, 0);
    add_pixel(0, 255, 0, 0); add_pixel(255, 255, 255, 1); add_pixel(1, 2, 3, 0);
    add_pixel(255, 255, 255, 0); add_pixel(254, 128, 127, 0); add_pixel(0, 0, 0, 0);
    add_pixel(9, 9, 9, 1); add_pixel(255, 255, 255, 0); add_pixel(7, 7, 7, 1);
    add_pixel(0, 0, 0, 1);
    add_cfg(REG_FRAME_WIDTH, 1);
    add_cfg(REG_FRAME_HEIGHT, 1);
    add_pixel(255, 0, 128, 0); add_pixel(3, 3, 3, 0);
    add_cfg(REG_FRAME_WIDTH, 2);
    add_pixel(255, 255, 255, 0); add_pixel(0, 0, 0, 0);
    add_pixel(0, 0, 0, 1); add_pixel(0, 0, 0, 1); add_pixel(0, 0, 0, 1);
    add_sync();
    // register extremes, out of range values included
    add_cfg(REG_FRAME_WIDTH, 2047);
    add_cfg(REG_FRAME_HEIGHT, 2);
    add_frame(0, 1040);
    add_sync();
    add_cfg(REG_FRAME_WIDTH, 5);
    add_cfg(REG_FRAME_HEIGHT, 0);
    add_frame(0, 0);
    add_cfg(REG_FRAME_WIDTH, 0);
    add_cfg(REG_FRAME_HEIGHT, 8191);
    add_frame(20, 40);
    add_sync();
    add_cfg(REG_FRAME_HEIGHT, 4096);
    add_cfg(REG_FRAME_WIDTH, 1);
    add_frame(0, 12);
    add_sync();
    add_cfg(REG_FRAME_WIDTH, 6);
    add_cfg(REG_FRAME_HEIGHT, 4);
    add_frame(0, 10);
    add_sync();
    // random settings and frames
    count = pending_beats.size();
    while (count < 1550) begin
      ws = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      hs = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      if ($urandom_range(0, 1)) begin
        add_cfg(REG_FRAME_WIDTH, ws);
        add_cfg(REG_FRAME_HEIGHT, hs);
      end else begin
        add_cfg(REG_FRAME_HEIGHT, hs);
        add_cfg(REG_FRAME_WIDTH, ws);
      end
      repeat ($urandom_range(1, 3)) begin
        add_frame(($urandom_range(0, 3) == 0) ? 15 : 0, 0);
        count += gen_w * gen_h + gen_w + 1;
      end
      if ($urandom_range(0, 9) == 0) begin
        add_frame(0, $urandom_range(1, gen_w * gen_h));
        add_sync();
      end
      if ($urandom_range(0, 19) == 0) add_sync();
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_beats.size() > 0 || push_i || cfg_valid_i || blurred_q.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && blurred_q.size() == 0) begin
      $display("box_blur_3x3_rgb_test passed");
    end else begin
      $display("box_blur_3x3_rgb_test failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("box_blur_3x3_rgb_test failed");
    $finish;
  end

endmodule
